// ----- sv/assert_macros.svh -----
// Assertion macros shared by the mapper RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, also evaluated while reset is asserted.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/cbm_pkg.sv -----
// Types and constants for the cartridge bank mapper.
// No dependencies; imported by cartridge_bank_mapper_with_cycle_irq.
package cbm_pkg;

    localparam int PRG_BANK_BITS = 8;
    localparam int CHR_BANK_BITS = 5;

    localparam int ADDR_W  = 22;
    localparam int TIMER_W = 12;

    localparam logic [TIMER_W-1:0] TIMER_LOAD = 12'd4095;

    // Register window 0x6000-0x7FFF is the top three address bits 011
    localparam logic [2:0] REG_WIN_TOP = 3'b011;

    localparam logic [7:0] PAT_QUARTER_EN = 8'h80;
    localparam logic [7:0] PAT_HI_MASK    = 8'h1C;
    localparam logic [7:0] PAT_MASK       = 8'h1F;

    localparam logic [8:0] LINE_Q1_START = 9'd63;
    localparam logic [8:0] LINE_Q2_START = 9'd127;
    localparam logic [8:0] LINE_Q3_START = 9'd191;
    localparam logic [8:0] LINE_Q3_END   = 9'd240;

    typedef enum logic [1:0] {
        ACT_WRITE    = 2'd0,
        ACT_TICK     = 2'd1,
        ACT_CPU_READ = 2'd2,
        ACT_PPU_READ = 2'd3
    } cbm_action_t;

    typedef struct packed {
        cbm_action_t action;
        logic [15:0] cpu_addr;
        logic [7:0]  write_data;
        logic [7:0]  cycles;
        logic [8:0]  scanline;
        logic [13:0] ppu_addr;
    } cbm_in_t;

    typedef struct packed {
        logic              irq_line;
        logic [ADDR_W-1:0] mapped_addr;
        logic              addr_hit;
    } cbm_out_t;

    function automatic logic [1:0] scan_quarter(input logic [8:0] line);
        logic [1:0] q;
        if (line < LINE_Q1_START || line > LINE_Q3_END)
            q = 2'd0;
        else if (line < LINE_Q2_START)
            q = 2'd1;
        else if (line < LINE_Q3_START)
            q = 2'd2;
        else
            q = 2'd3;
        return q;
    endfunction

endpackage

// ----- sv/cartridge_bank_mapper_with_cycle_irq.sv -----
// Cartridge bank mapper with CPU-cycle IRQ timer: input register, one pass of
// translate / state-update logic, result register. One result per item.
// Throughput: one item per cycle; only a stalled result register holds intake.
// Reset (rst_n low, async): bank registers, timer and IRQ clear to zero,
// both pipeline stages empty.
`include "assert_macros.svh"

module cartridge_bank_mapper_with_cycle_irq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  cbm_pkg::cbm_in_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output cbm_pkg::cbm_out_t out_data
);
    import cbm_pkg::*;

    logic               in_valid_reg;
    cbm_in_t            in_reg;
    logic               out_valid_reg;
    cbm_out_t           out_reg;
    cbm_out_t           out_next;

    logic [7:0]         program_bank_reg, program_bank_next;
    logic [7:0]         pattern_bank_reg, pattern_bank_next;
    logic [TIMER_W-1:0] cycle_timer_reg,  cycle_timer_next;
    logic               irq_pending_reg,  irq_pending_next;

    logic               advance;
    logic               fire;
    logic [PRG_BANK_BITS-1:0] cpu_rom_bank;
    logic [7:0]         ppu_bank_raw;
    logic [CHR_BANK_BITS-1:0] ppu_rom_bank;
    logic [TIMER_W-1:0] tick_cycles;

    // Result register can take a new item when empty or being drained
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign tick_cycles = TIMER_W'(in_reg.cycles);

    always_comb
    begin
        program_bank_next = program_bank_reg;
        pattern_bank_next = pattern_bank_reg;
        cycle_timer_next  = cycle_timer_reg;
        irq_pending_next  = irq_pending_reg;
        out_next.mapped_addr = '0;
        out_next.addr_hit    = 1'b0;
        cpu_rom_bank  = '1;
        ppu_bank_raw  = '1;
        ppu_rom_bank  = '1;

        unique case (in_reg.action)
            ACT_WRITE:
            begin
                if (in_reg.cpu_addr[15:13] == REG_WIN_TOP) begin
                    if (!in_reg.cpu_addr[0]) begin
                        program_bank_next = in_reg.write_data;
                        irq_pending_next  = 1'b0;
                        if (in_reg.write_data[7])
                            cycle_timer_next = TIMER_LOAD;
                    end
                    else begin
                        pattern_bank_next = in_reg.write_data;
                    end
                end
            end
            ACT_TICK:
            begin
                if (cycle_timer_reg != '0 && tick_cycles != '0) begin
                    if (cycle_timer_reg <= tick_cycles) begin
                        cycle_timer_next = '0;
                        irq_pending_next = 1'b1;
                    end
                    else begin
                        cycle_timer_next = cycle_timer_reg - tick_cycles;
                    end
                end
            end
            ACT_CPU_READ:
            begin
                if (in_reg.cpu_addr[15]) begin
                    // Upper 16K window is fixed to the last bank
                    if (!in_reg.cpu_addr[14])
                        cpu_rom_bank = program_bank_reg[PRG_BANK_BITS-1:0];
                    out_next.mapped_addr = ADDR_W'({cpu_rom_bank, in_reg.cpu_addr[13:0]});
                    out_next.addr_hit    = 1'b1;
                end
            end
            ACT_PPU_READ:
            begin
                if (in_reg.ppu_addr[13] == 1'b0) begin
                    if (!in_reg.ppu_addr[12]) begin
                        if ((pattern_bank_reg & PAT_QUARTER_EN) != '0)
                            ppu_bank_raw = (pattern_bank_reg & PAT_HI_MASK)
                                         | {6'd0, scan_quarter(in_reg.scanline)};
                        else
                            ppu_bank_raw = pattern_bank_reg & PAT_MASK;
                        ppu_rom_bank = ppu_bank_raw[CHR_BANK_BITS-1:0];
                    end
                    out_next.mapped_addr = ADDR_W'({ppu_rom_bank, in_reg.ppu_addr[11:0]});
                    out_next.addr_hit    = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        out_next.irq_line = irq_pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            program_bank_reg <= '0;
            pattern_bank_reg <= '0;
            cycle_timer_reg  <= '0;
            irq_pending_reg  <= 1'b0;
        end
        else begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (fire) begin
                program_bank_reg <= program_bank_next;
                pattern_bank_reg <= pattern_bank_next;
                cycle_timer_reg  <= cycle_timer_next;
                irq_pending_reg  <= irq_pending_next;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_reg <= in_data;
        if (fire)
            out_reg <= out_next;
    end

    `ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> in_valid_reg, "stall with empty input register")
    `ASSERT_CLK(a_irq_timer_zero, irq_pending_reg |-> cycle_timer_reg == '0, "irq pending with live timer")
    `ASSERT_CLK(a_miss_zero_addr, (out_valid_reg && !out_reg.addr_hit) |-> out_reg.mapped_addr == '0, "unmapped result carries address")
    `ASSERT_CLK(a_state_hold, !fire |=> $stable(program_bank_reg) && $stable(pattern_bank_reg) && $stable(cycle_timer_reg), "bank state moved without a transfer")
    `ASSERT_CLK(a_irq_matches_state, fire |=> out_reg.irq_line == irq_pending_reg, "result irq differs from state")

endmodule
